/* design/wfd_pkg.sv */
// Shared types and codes for the WebSocket frame decoder.
`timescale 1ns / 1ps

package wfd_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [5:0] {
        PH_OPCODE  = 6'b000001,
        PH_LENGTH  = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASKKEY = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_SKIP    = 6'b100000
    } t_phase;

    localparam int unsigned LEN_CODE_EXT16 = 126;
    localparam int unsigned LEN_CODE_EXT64 = 127;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  opcode_byte;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        frame_last;
    } t_result;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_last;
    } t_item;

endpackage

/* design/wfd_in_reg.sv */
// Input register stage: holds one received beat until the parser takes it.
`timescale 1ns / 1ps

module wfd_in_reg
    import wfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* design/wfd_parser.sv */
// Frame header parser and payload unmasker, one byte per fire.
`timescale 1ns / 1ps

module wfd_parser
    import wfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_res
);

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_first,  n_first;
    logic [15:0] r_len,    n_len;
    logic        r_masked, n_masked;
    logic [31:0] r_key,    n_key;
    logic [1:0]  r_hcnt,   n_hcnt;
    logic [15:0] r_pcnt,   n_pcnt;

    always_comb begin
        logic [7:0] b;
        logic       last;
        logic [6:0] code;
        logic [7:0] key_byte;
        logic       do_err;
        logic       do_hdr;

        b        = i_item.rx_byte;
        last     = i_item.buffer_last;
        code     = b[6:0];
        key_byte = 8'd0;
        do_err   = 1'b0;
        do_hdr   = 1'b0;

        n_phase  = r_phase;
        n_first  = r_first;
        n_len    = r_len;
        n_masked = r_masked;
        n_key    = r_key;
        n_hcnt   = r_hcnt;
        n_pcnt   = r_pcnt;
        o_res    = '0;

        case (r_phase)
            PH_OPCODE: begin
                n_first = b;
                if (last) begin
                    do_err = 1'b1;
                end else begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_masked = b[7];
                n_hcnt   = 2'd0;
                n_key    = 32'd0;
                if (code == 7'(LEN_CODE_EXT64)) begin
                    do_err = 1'b1;
                end else if (code == 7'(LEN_CODE_EXT16)) begin
                    n_len = 16'd0;
                    if (last) begin
                        do_err = 1'b1;
                    end else begin
                        n_phase = PH_EXTLEN;
                    end
                end else begin
                    n_len = {9'd0, code};
                    if (b[7]) begin
                        if (last) begin
                            do_err = 1'b1;
                        end else begin
                            n_phase = PH_MASKKEY;
                        end
                    end else begin
                        do_hdr = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                n_len = {r_len[7:0], b};
                if (r_hcnt == 2'd0) begin
                    n_hcnt = 2'd1;
                    do_err = last;
                end else begin
                    n_hcnt = 2'd0;
                    if (r_masked) begin
                        if (last) begin
                            do_err = 1'b1;
                        end else begin
                            n_phase = PH_MASKKEY;
                        end
                    end else begin
                        do_hdr = 1'b1;
                    end
                end
            end
            PH_MASKKEY: begin
                n_key = {r_key[23:0], b};
                if (r_hcnt != 2'd3) begin
                    n_hcnt = r_hcnt + 2'd1;
                    do_err = last;
                end else begin
                    n_hcnt = 2'd0;
                    do_hdr = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                // key bytes cycle from the most significant one
                if (r_masked) begin
                    case (r_pcnt[1:0])
                        2'd0:    key_byte = r_key[31:24];
                        2'd1:    key_byte = r_key[23:16];
                        2'd2:    key_byte = r_key[15:8];
                        default: key_byte = r_key[7:0];
                    endcase
                end
                n_pcnt = r_pcnt + 16'd1;
                if (n_pcnt == r_len) begin
                    n_phase            = last ? PH_OPCODE : PH_SKIP;
                    o_res.valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.payload_byte = b ^ key_byte;
                    o_res.frame_last   = 1'b1;
                end else if (last) begin
                    do_err = 1'b1;
                end else begin
                    o_res.valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.payload_byte = b ^ key_byte;
                end
            end
            PH_SKIP: begin
                n_phase = last ? PH_OPCODE : PH_SKIP;
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase

        if (do_hdr) begin
            n_pcnt = 16'd0;
            if (n_len == 16'd0) begin
                n_phase           = last ? PH_OPCODE : PH_SKIP;
                o_res.valid       = 1'b1;
                o_res.kind        = KIND_HEADER;
                o_res.opcode_byte = r_first;
                o_res.frame_last  = 1'b1;
            end else if (last) begin
                // buffer ended before any payload arrived
                do_err = 1'b1;
            end else begin
                n_phase              = PH_PAYLOAD;
                o_res.valid          = 1'b1;
                o_res.kind           = KIND_HEADER;
                o_res.opcode_byte    = r_first;
                o_res.payload_length = n_len;
            end
        end

        if (do_err) begin
            n_phase          = last ? PH_OPCODE : PH_SKIP;
            o_res            = '0;
            o_res.valid      = 1'b1;
            o_res.kind       = KIND_ERROR;
            o_res.frame_last = 1'b1;
        end

        if (!i_fire) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_first  <= 8'd0;
            r_len    <= 16'd0;
            r_masked <= 1'b0;
            r_key    <= 32'd0;
            r_hcnt   <= 2'd0;
            r_pcnt   <= 16'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_len    <= n_len;
            r_masked <= n_masked;
            r_key    <= n_key;
            r_hcnt   <= n_hcnt;
            r_pcnt   <= n_pcnt;
        end
    end

endmodule

/* design/wfd_out_reg.sv */
// Result register: holds one decoded beat until the sink takes it.
`timescale 1ns / 1ps

module wfd_out_reg
    import wfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res.valid) begin
            r_res <= i_res;
        end
    end

endmodule

/* design/websocket_frame_decoder_core.sv */
// Top level of the WebSocket frame decoder.
`timescale 1ns / 1ps

// Decodes one WebSocket frame (16-bit lengths) from each receive buffer, one
// byte per beat. Each buffer ends with tlast. A header beat reports the first
// frame byte and payload length, then one beat per payload byte, unmasked by
// the cycling 4-byte key; tlast marks the last result of a frame. A 64-bit
// length code or a buffer that ends early gives an error beat. The block takes
// one byte every cycle while the result side does not stall; each byte passes
// the input register, the parser's combinational decode and the result register.
module websocket_frame_decoder_core
    import wfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] rx_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [7:0] opcode_byte, [23:8] payload_length,
                                         // [31:24] payload_byte
    output logic [1:0]  o_m_axis_tuser,  // [1:0] kind
    output logic        o_m_axis_tlast
);

    t_item   in_item;
    t_item   pipe_item;
    logic    pipe_valid;
    logic    out_ready;
    logic    fire;
    t_result res;
    t_result out_res;

    assign in_item.rx_byte     = i_s_axis_tdata;
    assign in_item.buffer_last = i_s_axis_tlast;
    assign fire                = pipe_valid && out_ready;

    wfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (pipe_valid),
        .i_take  (fire),
        .o_item  (pipe_item)
    );

    wfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (pipe_item),
        .o_res   (res)
    );

    wfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {out_res.payload_byte, out_res.payload_length,
                             out_res.opcode_byte};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.frame_last;

endmodule

/* tb/ws_frame_checker.sv */
// Checker for the WebSocket frame decoder: predicts result beats and compares them.
`timescale 1ns / 1ps

module ws_frame_checker
    import wfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  opcode;
        logic [15:0] length;
        logic [7:0]  data;
        logic        last;
    } ws_result_t;

    ws_result_t expected_results[$];
    int         fail_count = 0;

    // decoder state mirror
    t_phase      st_phase;
    logic [7:0]  st_first;
    logic [15:0] st_len;
    logic        st_masked;
    logic [31:0] st_key;
    logic [2:0]  st_hcount;
    logic [15:0] st_pcount;

    function automatic bit flag_error(input logic buf_end, output ws_result_t res);
        st_phase = buf_end ? PH_OPCODE : PH_SKIP;
        res      = '0;
        res.kind = KIND_ERROR;
        res.last = 1'b1;
        return 1'b1;
    endfunction

    // header complete: report it, or flag a frame cut short by the buffer end
    function automatic bit finish_header(input logic buf_end, output ws_result_t res);
        st_pcount = '0;
        res       = '0;
        if (st_len == 16'd0) begin
            st_phase   = buf_end ? PH_OPCODE : PH_SKIP;
            res.kind   = KIND_HEADER;
            res.opcode = st_first;
            res.last   = 1'b1;
            return 1'b1;
        end
        if (buf_end)
            return flag_error(1'b1, res);
        st_phase   = PH_PAYLOAD;
        res.kind   = KIND_HEADER;
        res.opcode = st_first;
        res.length = st_len;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic buf_end,
                                       output ws_result_t res);
        logic [6:0] code;
        logic [7:0] key_byte;
        res = '0;
        case (st_phase)
            PH_OPCODE: begin
                st_first = b;
                if (buf_end)
                    return flag_error(1'b1, res);
                st_phase = PH_LENGTH;
                return 1'b0;
            end
            PH_LENGTH: begin
                st_masked = b[7];
                code      = b[6:0];
                st_hcount = '0;
                st_key    = '0;
                if (code == LEN_CODE_EXT64)
                    return flag_error(buf_end, res);
                if (code == LEN_CODE_EXT16) begin
                    st_len = '0;
                    if (buf_end)
                        return flag_error(1'b1, res);
                    st_phase = PH_EXTLEN;
                    return 1'b0;
                end
                st_len = {9'd0, code};
                if (st_masked) begin
                    if (buf_end)
                        return flag_error(1'b1, res);
                    st_phase = PH_MASKKEY;
                    return 1'b0;
                end
                return finish_header(buf_end, res);
            end
            PH_EXTLEN: begin
                st_len    = {st_len[7:0], b};
                st_hcount = st_hcount + 3'd1;
                if (st_hcount < 3'd2) begin
                    if (buf_end)
                        return flag_error(1'b1, res);
                    return 1'b0;
                end
                st_hcount = '0;
                if (st_masked) begin
                    if (buf_end)
                        return flag_error(1'b1, res);
                    st_phase = PH_MASKKEY;
                    return 1'b0;
                end
                return finish_header(buf_end, res);
            end
            PH_MASKKEY: begin
                st_key    = {st_key[23:0], b};
                st_hcount = st_hcount + 3'd1;
                if (st_hcount < 3'd4) begin
                    if (buf_end)
                        return flag_error(1'b1, res);
                    return 1'b0;
                end
                st_hcount = '0;
                return finish_header(buf_end, res);
            end
            PH_PAYLOAD: begin
                // key bytes cycle from the most significant one
                key_byte  = st_masked ? st_key[8 * (3 - int'(st_pcount[1:0])) +: 8] : 8'd0;
                st_pcount = st_pcount + 16'd1;
                if (st_pcount == st_len) begin
                    st_phase = buf_end ? PH_OPCODE : PH_SKIP;
                    res.kind = KIND_PAYLOAD;
                    res.data = b ^ key_byte;
                    res.last = 1'b1;
                    return 1'b1;
                end
                if (buf_end)
                    return flag_error(1'b1, res);
                res.kind = KIND_PAYLOAD;
                res.data = b ^ key_byte;
                return 1'b1;
            end
            default: begin
                st_phase = buf_end ? PH_OPCODE : PH_SKIP;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        ws_result_t got;
        ws_result_t want;
        ws_result_t next_res;
        if (!i_rst_n) begin
            st_phase  = PH_OPCODE;
            st_first  = '0;
            st_len    = '0;
            st_masked = 1'b0;
            st_key    = '0;
            st_hcount = '0;
            st_pcount = '0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.kind   = t_kind'(i_m_tuser);
                got.opcode = i_m_tdata[7:0];
                got.length = i_m_tdata[23:8];
                got.data   = i_m_tdata[31:24];
                got.last   = i_m_tlast;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result beat with nothing expected: ",
                                  "kind %0d op %02h len %0d data %02h last %0b"},
                                 got.kind, got.opcode, got.length, got.data, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected kind %0d op %02h len %0d ",
                                      "data %02h last %0b, got kind %0d op %02h ",
                                      "len %0d data %02h last %0b"},
                                     want.kind, want.opcode, want.length, want.data,
                                     want.last, got.kind, got.opcode, got.length,
                                     got.data, got.last);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (decode_byte(i_s_tdata, i_s_tlast, next_res))
                    expected_results.push_back(next_res);
            end
        end
        o_errors  <= fail_count;
        o_pending <= expected_results.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the WebSocket frame decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import wfd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] rx_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] opcode_byte, [23:8] payload_length,
                                    // [31:24] payload_byte
    logic [1:0]  m_tuser;           // [1:0] kind
    logic        m_tlast;

    int errors;
    int pending;
    int tx_idle_pct  = 11;
    int rx_idle_pct  = 88;
    int traffic_mode = 1;
    int sent_bytes   = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    logic [7:0] frame_bytes[$];

    always #10 i_clk = ~i_clk;

    websocket_frame_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    ws_frame_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // result side; one long hold-off when the no-idle mode begins
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (traffic_mode == 3 && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drive_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    // one receive buffer; tlast on its final byte
    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            drive_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        sent_bytes += frame_bytes.size();
    endtask

    task automatic build_random_frame();
        logic [7:0]  opcode;
        logic        masked;
        logic [6:0]  code;
        logic [15:0] len;
        int          sel;
        int          n_pay;
        int          keep;
        bit          huge;
        bit          broken;
        frame_bytes.delete();
        opcode = 8'($urandom);
        masked = 1'($urandom_range(0, 1));
        sel    = $urandom_range(0, 99);
        broken = ($urandom_range(0, 99) < 25);
        huge   = 1'b0;
        if (sel < 60) begin
            len  = 16'($urandom_range(0, 15));
            code = len[6:0];
        end else if (sel < 66) begin
            len  = 16'($urandom_range(16, 125));
            code = len[6:0];
        end else if (sel < 90) begin
            code = 7'(LEN_CODE_EXT16);
            len  = 16'($urandom_range(0, 40));
        end else begin
            // full 16-bit length, payload cut short
            code = 7'(LEN_CODE_EXT16);
            len  = 16'($urandom);
            huge = 1'b1;
        end
        if (broken && $urandom_range(0, 3) == 0)
            code = 7'(LEN_CODE_EXT64);
        frame_bytes.push_back(opcode);
        frame_bytes.push_back({masked, code});
        if (code == LEN_CODE_EXT64) begin
            n_pay = $urandom_range(0, 4);
            repeat (n_pay) frame_bytes.push_back(8'($urandom));
        end else begin
            if (code == LEN_CODE_EXT16) begin
                frame_bytes.push_back(len[15:8]);
                frame_bytes.push_back(len[7:0]);
            end
            if (masked)
                repeat (4) frame_bytes.push_back(8'($urandom));
            n_pay = huge ? $urandom_range(0, 6) : int'(len);
            repeat (n_pay) frame_bytes.push_back(8'($urandom));
            if (broken) begin
                keep = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end else if ($urandom_range(0, 4) == 0) begin
                n_pay = $urandom_range(1, 3);
                repeat (n_pay) frame_bytes.push_back(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opcode byte alone
        frame_bytes = '{8'hFF};
        send_frame();
        // 64-bit length code, rest of buffer skipped
        frame_bytes = '{8'h82, 8'h7F, 8'h55};
        send_frame();
        // empty payload
        frame_bytes = '{8'h89, 8'h00};
        send_frame();
        // masked, one payload byte
        frame_bytes = '{8'h81, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'hAB};
        send_frame();
        // extended length 1, unmasked, trailing byte skipped
        frame_bytes = '{8'h02, 8'h7E, 8'h00, 8'h01, 8'hFF, 8'h33};
        send_frame();
        // buffer ends at header of non-empty payload
        frame_bytes = '{8'h01, 8'h03};
        send_frame();
        // length 65535, buffer ends inside payload
        frame_bytes = '{8'h82, 8'h7E, 8'hFF, 8'hFF, 8'h00};
        send_frame();

        for (int mode = 1; mode <= 3; mode++) begin
            traffic_mode = mode;
            tx_idle_pct  = (mode == 1) ? 11 : (mode == 2) ? 88 : 0;
            rx_idle_pct  = (mode == 1) ? 88 : (mode == 2) ? 11 : 0;
            while (sent_bytes < 25 + 210 * mode) begin
                build_random_frame();
                send_frame();
            end
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
design/wfd_pkg.sv
design/wfd_in_reg.sv
design/wfd_parser.sv
design/wfd_out_reg.sv
design/websocket_frame_decoder_core.sv
tb/ws_frame_checker.sv
tb/testbench.sv
